[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the two-class queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge, quiet while reset is asserted.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked from the same edge.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/tcfq_pkg.sv]
// Package: widths, codes and state type of the two-class queue.
package tcfq_pkg;

  localparam int ID_W             = 16;
  localparam int DEF_QUEUE_DEPTH  = 16;
  localparam int DEF_ID_BITS      = 16;

  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_ANY     = 2'd1,
    ACT_DOG     = 2'd2,
    ACT_CAT     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  localparam logic KIND_DOG = 1'b0;
  localparam logic KIND_CAT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_SH_RD,
    S_SH_WR,
    S_POST
  } state_t;

endpackage

[hw/rtl/tcfq_if.sv]
// Handshake channel interfaces for requests and results.
interface tcfq_in_if import tcfq_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      action;
  logic            animal_kind;
  logic [ID_W-1:0] animal_id;

  modport source (output valid, action, animal_kind, animal_id, input ready);
  modport sink   (input valid, action, animal_kind, animal_id, output ready);
endinterface

interface tcfq_out_if import tcfq_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      status;
  logic            out_kind;
  logic [ID_W-1:0] out_id;

  modport source (output valid, status, out_kind, out_id, input ready);
  modport sink   (input valid, status, out_kind, out_id, output ready);
endinterface

[hw/rtl/tcfq_store.sv]
// Entry store: one write port, one registered read port.
module tcfq_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 17
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/two_class_fifo_typed_dequeue.sv]
// Top level: arrival-ordered two-kind queue with typed dequeue.
// Sequence: enqueue (also when full) and dequeue from an empty queue go straight to posting
//   the result; a dequeue reads and compares entries from the head up to the first hit, then
//   shifts every later entry down (read, write) and posts; a miss scans all held entries.
// Throughput: one transaction at a time, and posting waits on any out_ready stall; the single
//   store read port and the shared kind compare / index counter set the pace.
module two_class_fifo_typed_dequeue
  import tcfq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int ID_BITS     = DEF_ID_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  tcfq_in_if.sink      in_ch,
  tcfq_out_if.source   out_ch
);

  `include "assert_macros.svh"

  // Reset (rst_n low, synchronous) empties the queue and drops any pending result.

  // Stored id keeps only the bits that can ever be nonzero.
  localparam int SW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int EW = SW + 1;                      // kind above id
  localparam int AW = $clog2(QUEUE_DEPTH);         // store address
  localparam int CW = $clog2(QUEUE_DEPTH + 1);     // fill count

  state_t         state_r,       state_nxt;
  logic [CW-1:0]  count_r,       count_nxt;
  logic [AW-1:0]  idx_r,         idx_nxt;
  action_t        act_r,         act_nxt;
  status_t        res_status_r,  res_status_nxt;
  logic           res_kind_r,    res_kind_nxt;
  logic [SW-1:0]  res_id_r,      res_id_nxt;
  logic           out_valid_r,   out_valid_nxt;
  status_t        out_status_r,  out_status_nxt;
  logic           out_kind_r,    out_kind_nxt;
  logic [SW-1:0]  out_id_r,      out_id_nxt;

  // Store port signals
  logic           st_we;
  logic [AW-1:0]  st_waddr;
  logic [EW-1:0]  st_wdata;
  logic [AW-1:0]  st_raddr;
  logic [EW-1:0]  st_rdata;

  logic           in_acc;
  logic [CW-1:0]  idx_inc;       // idx + 1 in count width
  logic           want_kind;     // kind asked for by a typed dequeue
  logic           hit;           // shared compare: entry qualifies for removal
  logic [ID_W-1:0] out_id_ext;

  tcfq_store #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EW)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (st_wdata),
    .rd_addr (st_raddr),
    .rd_data (st_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign idx_inc   = CW'(idx_r) + CW'(1);
  assign want_kind = (act_r == ACT_CAT) ? KIND_CAT : KIND_DOG;
  assign hit       = (act_r == ACT_ANY) || (st_rdata[EW-1] == want_kind);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    act_nxt        = act_r;
    res_status_nxt = res_status_r;
    res_kind_nxt   = res_kind_r;
    res_id_nxt     = res_id_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    st_we          = 1'b0;
    st_waddr       = idx_r;
    st_wdata       = st_rdata;
    st_raddr       = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          act_nxt        = action_t'(in_ch.action);
          idx_nxt        = '0;
          res_kind_nxt   = 1'b0;
          res_id_nxt     = '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_POST;
          if (action_t'(in_ch.action) == ACT_ENQUEUE) begin
            if (count_r == CW'(QUEUE_DEPTH)) begin
              res_status_nxt = ST_FULL;
            end else begin
              // append at the tail straight from the request
              st_we     = 1'b1;
              st_waddr  = count_r[AW-1:0];
              st_wdata  = {in_ch.animal_kind, in_ch.animal_id[SW-1:0]};
              count_nxt = count_r + CW'(1);
            end
          end else if (count_r == '0) begin
            res_status_nxt = ST_NONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      S_RD: begin
        st_raddr  = idx_r;
        state_nxt = S_CMP;
      end

      S_CMP: begin
        if (hit) begin
          res_kind_nxt = st_rdata[EW-1];
          res_id_nxt   = st_rdata[SW-1:0];
          if (idx_inc == count_r) begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_POST;
          end else begin
            state_nxt = S_SH_RD;
          end
        end else if (idx_inc == count_r) begin
          res_status_nxt = ST_NONE;
          state_nxt      = S_POST;
        end else begin
          idx_nxt   = idx_inc[AW-1:0];
          state_nxt = S_RD;
        end
      end

      // close the gap: move entry idx+1 down to idx
      S_SH_RD: begin
        st_raddr  = idx_inc[AW-1:0];
        state_nxt = S_SH_WR;
      end

      S_SH_WR: begin
        st_we    = 1'b1;
        st_waddr = idx_r;
        st_wdata = st_rdata;
        if (idx_inc == count_r - CW'(1)) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_POST;
        end else begin
          idx_nxt   = idx_inc[AW-1:0];
          state_nxt = S_SH_RD;
        end
      end

      S_POST: begin
        // hold here while the previous result is still unclaimed
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_kind_nxt   = res_kind_r;
          out_id_nxt     = res_id_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    act_r        <= act_nxt;
    res_status_r <= res_status_nxt;
    res_kind_r   <= res_kind_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_kind_r   <= out_kind_nxt;
    out_id_r     <= out_id_nxt;
  end

  always_comb begin
    out_id_ext         = '0;
    out_id_ext[SW-1:0] = out_id_r;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.out_kind = out_kind_r;
  assign out_ch.out_id   = out_id_ext;

  // Fill count stays within the store.
  `ASSERT_ALWAYS(a_count_bound, count_r <= CW'(QUEUE_DEPTH), "entry count beyond depth")

  // An accepted enqueue with room grows the queue by one.
  `ASSERT_NEXT(a_enq_grows, in_acc && action_t'(in_ch.action) == ACT_ENQUEUE && count_r != CW'(QUEUE_DEPTH), count_r == $past(count_r) + CW'(1), "enqueue did not grow count")

  // Shifting only touches places below the fill count.
  `ASSERT_IMPL(a_shift_range, state_r == S_SH_WR || state_r == S_SH_RD, idx_inc < count_r, "shift past tail")

  // Failed results carry no entry.
  `ASSERT_IMPL(a_empty_payload, out_valid_r && out_status_r != ST_OK, !out_kind_r && out_id_r == '0, "payload on failed result")

endmodule
